// ===== rtl/positional_sequential_list_core_assert.svh =====
// Assertion macros for the positional sequential list core.
`ifndef POSITIONAL_SEQUENTIAL_LIST_CORE_ASSERT_SVH
`define POSITIONAL_SEQUENTIAL_LIST_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PSL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("positional list check failed");

// Next-cycle implication, disabled while in reset.
`define PSL_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("positional list check failed");

`endif

// ===== rtl/psl_pkg.sv =====
// ----------------------------------------------------------------------------
// psl_pkg
// Shared constants, record type and controller/datapath interface structs
// for the positional sequential list core.
// ----------------------------------------------------------------------------
package psl_pkg;

	localparam int CAPACITY = 128;
	localparam int POS_W    = 8;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic [2:0] KIND_INSERT = 3'd0;
	localparam logic [2:0] KIND_DELETE = 3'd1;
	localparam logic [2:0] KIND_GET    = 3'd2;
	localparam logic [2:0] KIND_LOCATE = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic signed [31:0] key;
		logic [63:0]        payload;
		logic [7:0]         tag;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic decode;
		logic ins_step;
		logic ins_put;
		logic del_step;
		logic del_done;
		logic get_rd;
		logic loc_step;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       op_ok;
		logic       ins_more;
		logic       del_more;
		logic       loc_more;
	} dp_sts_t;

endpackage

// ===== rtl/psl_ctrl.sv =====
// ----------------------------------------------------------------------------
// psl_ctrl
// Request sequencer: decodes the captured request and steps the datapath
// through shift, read and scan walks, then presents one result.
// ----------------------------------------------------------------------------
module psl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  psl_pkg::dp_sts_t  sts,
	output psl_pkg::dp_cmd_t  cmd
);
	import psl_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_DECODE    = 8'b0000_0010,
		S_INS_SHIFT = 8'b0000_0100,
		S_INS_PUT   = 8'b0000_1000,
		S_DEL_SHIFT = 8'b0001_0000,
		S_GET_RD    = 8'b0010_0000,
		S_LOC_SCAN  = 8'b0100_0000,
		S_RESP      = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = S_RESP;
				case (sts.kind)
					KIND_INSERT: if (sts.op_ok) state_d = S_INS_SHIFT;
					KIND_DELETE: if (sts.op_ok) state_d = S_DEL_SHIFT;
					KIND_GET:    if (sts.op_ok) state_d = S_GET_RD;
					KIND_LOCATE: state_d = S_LOC_SCAN;
					KIND_CLEAR:  cmd.clear = 1'b1;
					default:     state_d = S_RESP;
				endcase
			end
			S_INS_SHIFT: begin
				if (sts.ins_more) begin
					cmd.ins_step = 1'b1;
				end else begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT: begin
				cmd.ins_put = 1'b1;
				state_d     = S_RESP;
			end
			S_DEL_SHIFT: begin
				if (sts.del_more) begin
					cmd.del_step = 1'b1;
				end else begin
					cmd.del_done = 1'b1;
					state_d      = S_RESP;
				end
			end
			S_GET_RD: begin
				cmd.get_rd = 1'b1;
				state_d    = S_RESP;
			end
			S_LOC_SCAN: begin
				if (sts.loc_more) begin
					cmd.loc_step = 1'b1;
				end else begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

// ===== rtl/psl_dp.sv =====
// ----------------------------------------------------------------------------
// psl_dp
// List datapath: record memory with one write and one registered read port,
// length counter, walk pointer, request and result registers.
// ----------------------------------------------------------------------------
module psl_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  psl_pkg::dp_cmd_t   cmd,
	output psl_pkg::dp_sts_t   sts,
	input  logic [2:0]         kind,
	input  logic [7:0]         position,
	input  logic signed [31:0] key_field,
	input  logic [63:0]        payload_field,
	input  logic [7:0]         tag_field,
	output logic [1:0]         status,
	output logic [7:0]         found_position,
	output logic signed [31:0] read_key,
	output logic [63:0]        read_payload,
	output logic [7:0]         read_tag,
	output logic [7:0]         list_length,
	output logic               is_empty
);
	import psl_pkg::*;

	entry_t mem [CAPACITY];

	logic [2:0]       kind_q;
	logic [POS_W-1:0] pos_q;
	entry_t           new_q;
	entry_t           rd_data_q;
	logic [IDX_W-1:0] wa_q, ca_q;
	logic [CNT_W-1:0] count_q, ptr_q;
	logic             wr_pend_q, cmp_pend_q;
	logic [1:0]       status_q;
	logic [POS_W-1:0] found_q;

	logic [CMP_W-1:0] pos_x, cnt_x, ptr_x, pos_m1, ptr_m1, found_x;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en, hit, get_ok;
	logic [1:0]       status_d;

	assign pos_x   = CMP_W'(pos_q);
	assign cnt_x   = CMP_W'(count_q);
	assign ptr_x   = CMP_W'(ptr_q);
	assign pos_m1  = pos_x - CMP_W'(1);
	assign ptr_m1  = ptr_x - CMP_W'(1);
	assign found_x = CMP_W'(ca_q) + CMP_W'(1);

	always_comb begin
		status_d = ST_OK;
		case (kind_q)
			KIND_INSERT: begin
				if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
					status_d = ST_RANGE;
				end else if (cnt_x == CMP_W'(CAPACITY)) begin
					status_d = ST_FULL;
				end
			end
			KIND_DELETE, KIND_GET: begin
				if (pos_x == '0 || pos_x > cnt_x) begin
					status_d = ST_RANGE;
				end
			end
			default: status_d = ST_OK;
		endcase
	end

	assign hit = cmp_pend_q && (rd_data_q.key == new_q.key);

	assign sts.kind     = kind_q;
	assign sts.op_ok    = (status_d == ST_OK);
	assign sts.ins_more = (ptr_x >= pos_x);
	assign sts.del_more = (ptr_x < cnt_x);
	assign sts.loc_more = (ptr_x < cnt_x) && (found_q == '0) && !hit;

	assign rd_en = cmd.ins_step | cmd.del_step | cmd.get_rd | cmd.loc_step;

	always_comb begin
		if (cmd.ins_step) begin
			rd_addr = ptr_m1[IDX_W-1:0];
		end else if (cmd.get_rd) begin
			rd_addr = pos_m1[IDX_W-1:0];
		end else begin
			rd_addr = ptr_q[IDX_W-1:0];
		end
	end

	// record memory
	always_ff @(posedge clk) begin
		if (cmd.ins_put) begin
			mem[pos_m1[IDX_W-1:0]] <= new_q;
		end else if (wr_pend_q) begin
			mem[wa_q] <= rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// request and walk addresses
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q        <= kind;
			pos_q         <= position;
			new_q.key     <= key_field;
			new_q.payload <= payload_field;
			new_q.tag     <= tag_field;
		end
		if (cmd.ins_step) begin
			wa_q <= ptr_q[IDX_W-1:0];
		end else if (cmd.del_step) begin
			wa_q <= ptr_m1[IDX_W-1:0];
		end
		if (cmd.loc_step) begin
			ca_q <= ptr_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ptr_q      <= '0;
			wr_pend_q  <= 1'b0;
			cmp_pend_q <= 1'b0;
			status_q   <= ST_OK;
			found_q    <= '0;
		end else begin
			wr_pend_q  <= cmd.ins_step | cmd.del_step;
			cmp_pend_q <= cmd.loc_step;
			if (cmd.decode) begin
				status_q <= status_d;
				found_q  <= '0;
				case (kind_q)
					KIND_INSERT: ptr_q <= count_q;
					KIND_DELETE: ptr_q <= pos_x[CNT_W-1:0];
					default:     ptr_q <= '0;
				endcase
			end else begin
				if (hit && found_q == '0) begin
					found_q <= found_x[POS_W-1:0];
				end
				if (cmd.ins_step) begin
					ptr_q <= ptr_m1[CNT_W-1:0];
				end else if (cmd.del_step || cmd.loc_step) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
			end
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.ins_put) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.del_done) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign get_ok         = (kind_q == KIND_GET) && (status_q == ST_OK);
	assign status         = status_q;
	assign found_position = found_q;
	assign read_key       = get_ok ? rd_data_q.key : '0;
	assign read_payload   = get_ok ? rd_data_q.payload : '0;
	assign read_tag       = get_ok ? rd_data_q.tag : '0;
	assign list_length    = cnt_x[POS_W-1:0];
	assign is_empty       = (count_q == '0);

endmodule

// ===== rtl/positional_sequential_list_core.sv =====
// Clear, spare kinds and rejected requests go from decode straight to the result; get reads
// one record, delete shifts the entries after the position down, insert shifts the entries
// from the position up and then writes the new record, locate scans to a key match or the end;
// the walks all go through the single read port. One request at a time, the next accepted
// from the cycle after done. Results show for one cycle with done; the receiver cannot stall.
// Reset clears the length; stored records are undefined until written.
// ----------------------------------------------------------------------------
// positional_sequential_list_core
// Fixed-capacity ordered record list: insert, delete, get, locate, clear.
// ----------------------------------------------------------------------------
module positional_sequential_list_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         kind,
	input  logic [7:0]         position,
	input  logic signed [31:0] key_field,
	input  logic [63:0]        payload_field,
	input  logic [7:0]         tag_field,
	output logic               done,
	output logic [1:0]         status,
	output logic [7:0]         found_position,
	output logic signed [31:0] read_key,
	output logic [63:0]        read_payload,
	output logic [7:0]         read_tag,
	output logic [7:0]         list_length,
	output logic               is_empty
);
	import psl_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	psl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	psl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (kind),
		.position       (position),
		.key_field      (key_field),
		.payload_field  (payload_field),
		.tag_field      (tag_field),
		.status         (status),
		.found_position (found_position),
		.read_key       (read_key),
		.read_payload   (read_payload),
		.read_tag       (read_tag),
		.list_length    (list_length),
		.is_empty       (is_empty)
	);

endmodule

// ===== rtl/psl_checker.sv =====
// ----------------------------------------------------------------------------
// psl_checker
// Port-level checks on request/result sequencing, length flags and status codes of the list core.
// ----------------------------------------------------------------------------
`include "positional_sequential_list_core_assert.svh"

module psl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [7:0] list_length,
	input logic       is_empty
);
	import psl_pkg::*;

	`PSL_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done)
	`PSL_ASSERT_IMP(a_done_busy, done, busy)
	`PSL_ASSERT_NXT(a_done_single, done, !done && !busy)
	`PSL_ASSERT_IMP(a_empty_len, done, is_empty == (list_length == 8'd0))
	`PSL_ASSERT_IMP(a_status_code, done, status == ST_OK || status == ST_RANGE || status == ST_FULL)

endmodule

bind positional_sequential_list_core psl_checker u_psl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.list_length (list_length),
	.is_empty    (is_empty)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for positional_sequential_list_core: a directed table
// of requests, then random requests that fill, drain and probe the list,
// with every result checked against a shadow copy of the list or, for typed rows, the table.
// ----------------------------------------------------------------------------
module tb;
	import psl_pkg::*;

	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
	localparam int         RANDOM_REQUESTS  = 1900;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         pos;
		logic signed [31:0] key;
		logic [63:0]        payload;
		logic [7:0]         tag;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         found;
		logic signed [31:0] rkey;
		logic [63:0]        rpay;
		logic [7:0]         rtag;
		logic [7:0]         len;
		logic               empty;
	} res_t;

	typedef struct packed {
		req_t rq;
		logic typed;
		res_t want;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         kind;
	logic [7:0]         position;
	logic signed [31:0] key_field;
	logic [63:0]        payload_field;
	logic [7:0]         tag_field;
	logic               done;
	logic [1:0]         status;
	logic [7:0]         found_position;
	logic signed [31:0] read_key;
	logic [63:0]        read_payload;
	logic [7:0]         read_tag;
	logic [7:0]         list_length;
	logic               is_empty;

	entry_t shadow_list [CAPACITY];
	int     shadow_len;
	res_t   pending_results [$];
	int     mismatch_count;
	int     gap_pct;

	// typed rows: expected result read straight off the row; others come from the shadow list
	row_t directed_rows [0:22] = '{
		'{'{KIND_GET, 8'd1, 32'sd0, 64'd0, 8'd0}, 1'b1,
			'{ST_RANGE, 8'd0, 32'sd0, 64'd0, 8'd0, 8'd0, 1'b1}},
		'{'{KIND_DELETE, 8'd0, 32'sd0, 64'd0, 8'd0}, 1'b1,
			'{ST_RANGE, 8'd0, 32'sd0, 64'd0, 8'd0, 8'd0, 1'b1}},
		'{'{KIND_INSERT, 8'd2, 32'sd5, 64'd1, 8'd1}, 1'b1,
			'{ST_RANGE, 8'd0, 32'sd0, 64'd0, 8'd0, 8'd0, 1'b1}},
		'{'{KIND_INSERT, 8'd0, 32'sd5, 64'd1, 8'd1}, 1'b1,
			'{ST_RANGE, 8'd0, 32'sd0, 64'd0, 8'd0, 8'd0, 1'b1}},
		'{'{KIND_INSERT, 8'd1, 32'sh7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF}, 1'b1,
			'{ST_OK, 8'd0, 32'sd0, 64'd0, 8'd0, 8'd1, 1'b0}},
		'{'{KIND_INSERT, 8'd1, 32'sh8000_0000, 64'd0, 8'd0}, 1'b1,
			'{ST_OK, 8'd0, 32'sd0, 64'd0, 8'd0, 8'd2, 1'b0}},
		'{'{KIND_INSERT, 8'd3, 32'sd0, 64'hA5A5_5A5A_0F0F_F0F0, 8'h5A}, 1'b1,
			'{ST_OK, 8'd0, 32'sd0, 64'd0, 8'd0, 8'd3, 1'b0}},
		'{'{KIND_GET, 8'd1, 32'sd0, 64'd0, 8'd0}, 1'b1,
			'{ST_OK, 8'd0, 32'sh8000_0000, 64'd0, 8'd0, 8'd3, 1'b0}},
		'{'{KIND_GET, 8'd2, 32'sd0, 64'd0, 8'd0}, 1'b1,
			'{ST_OK, 8'd0, 32'sh7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'd3, 1'b0}},
		'{'{KIND_GET, 8'd255, 32'sd0, 64'd0, 8'd0}, 1'b1,
			'{ST_RANGE, 8'd0, 32'sd0, 64'd0, 8'd0, 8'd3, 1'b0}},
		'{'{KIND_LOCATE, 8'd0, 32'sh7FFF_FFFF, 64'd0, 8'd0}, 1'b1,
			'{ST_OK, 8'd2, 32'sd0, 64'd0, 8'd0, 8'd3, 1'b0}},
		'{'{KIND_LOCATE, 8'd9, 32'sd12345, 64'd0, 8'd0}, 1'b1,
			'{ST_OK, 8'd0, 32'sd0, 64'd0, 8'd0, 8'd3, 1'b0}},
		'{'{KIND_INSERT, 8'd2, 32'sd0, 64'h0123_4567_89AB_CDEF, 8'h3C}, 1'b0, '0},
		'{'{KIND_LOCATE, 8'd0, 32'sd0, 64'd0, 8'd0}, 1'b0, '0},
		'{'{KIND_INSERT, 8'd5, -32'sd1, 64'h8000_0000_0000_0001, 8'h81}, 1'b0, '0},
		'{'{KIND_DELETE, 8'd1, 32'sd0, 64'd0, 8'd0}, 1'b0, '0},
		'{'{KIND_DELETE, 8'd5, 32'sd0, 64'd0, 8'd0}, 1'b0, '0},
		'{'{KIND_GET, 8'd4, 32'sd0, 64'd0, 8'd0}, 1'b0, '0},
		'{'{KIND_SPARE_FIRST, 8'd1, 32'sd7, 64'd7, 8'd7}, 1'b0, '0},
		'{'{KIND_SPARE_LAST, 8'd2, 32'sd7, 64'd7, 8'd7}, 1'b0, '0},
		'{'{KIND_CLEAR, 8'd77, 32'sd0, 64'd0, 8'd0}, 1'b1,
			'{ST_OK, 8'd0, 32'sd0, 64'd0, 8'd0, 8'd0, 1'b1}},
		'{'{KIND_GET, 8'd1, 32'sd0, 64'd0, 8'd0}, 1'b1,
			'{ST_RANGE, 8'd0, 32'sd0, 64'd0, 8'd0, 8'd0, 1'b1}},
		'{'{KIND_LOCATE, 8'd255, 32'sd0, 64'd0, 8'd0}, 1'b1,
			'{ST_OK, 8'd0, 32'sd0, 64'd0, 8'd0, 8'd0, 1'b1}}
	};

	positional_sequential_list_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.position       (position),
		.key_field      (key_field),
		.payload_field  (payload_field),
		.tag_field      (tag_field),
		.done           (done),
		.status         (status),
		.found_position (found_position),
		.read_key       (read_key),
		.read_payload   (read_payload),
		.read_tag       (read_tag),
		.list_length    (list_length),
		.is_empty       (is_empty)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// applies one request to the shadow list and returns the result it yields
	function automatic res_t list_apply(req_t r);
		res_t o;
		int   p;
		int   j;
		o        = '0;
		o.status = ST_OK;
		p        = r.pos;
		case (r.kind)
			KIND_INSERT: begin
				if (p < 1 || p > shadow_len + 1)
					o.status = ST_RANGE;
				else if (shadow_len >= CAPACITY)
					o.status = ST_FULL;
				else begin
					for (j = shadow_len; j >= p; j--)
						shadow_list[j] = shadow_list[j - 1];
					shadow_list[p - 1] = '{key: r.key, payload: r.payload, tag: r.tag};
					shadow_len++;
				end
			end
			KIND_DELETE: begin
				if (p < 1 || p > shadow_len)
					o.status = ST_RANGE;
				else begin
					for (j = p - 1; j + 1 < shadow_len; j++)
						shadow_list[j] = shadow_list[j + 1];
					shadow_len--;
				end
			end
			KIND_GET: begin
				if (p < 1 || p > shadow_len)
					o.status = ST_RANGE;
				else begin
					o.rkey = shadow_list[p - 1].key;
					o.rpay = shadow_list[p - 1].payload;
					o.rtag = shadow_list[p - 1].tag;
				end
			end
			KIND_LOCATE: begin
				for (j = 0; j < shadow_len; j++) begin
					if (shadow_list[j].key == r.key) begin
						o.found = 8'(j + 1);
						break;
					end
				end
			end
			KIND_CLEAR: shadow_len = 0;
			default: ;
		endcase
		o.len   = 8'(shadow_len);
		o.empty = (shadow_len == 0);
		return o;
	endfunction

	// entered and left at a falling edge
	task automatic issue(req_t r, logic typed, res_t want);
		res_t model;
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start         <= 1'b1;
		kind          <= r.kind;
		position      <= r.pos;
		key_field     <= r.key;
		payload_field <= r.payload;
		tag_field     <= r.tag;
		do @(posedge clk); while (busy);
		model = list_apply(r);
		pending_results.push_back(typed ? want : model);
		@(negedge clk);
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("found_position", 64'(want.found), 64'(found_position));
				check_field("read_key", 64'(want.rkey), 64'(read_key));
				check_field("read_payload", want.rpay, read_payload);
				check_field("read_tag", 64'(want.rtag), 64'(read_tag));
				check_field("list_length", 64'(want.len), 64'(list_length));
				check_field("is_empty", 64'(want.empty), 64'(is_empty));
			end
		end
	end

	initial begin
		#50_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic signed [31:0] key_pool [0:7];
		req_t               r;
		bit                 grow;
		int                 sel;
		int                 n;
		key_pool = '{32'sd0, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sd1, 32'sd42, -32'sd42, 32'sh55AA_55AA};
		start          = 1'b0;
		kind           = KIND_INSERT;
		position       = '0;
		key_field      = '0;
		payload_field  = '0;
		tag_field      = '0;
		arst_n         = 1'b0;
		shadow_len     = 0;
		mismatch_count = 0;
		gap_pct        = 0;
		grow           = 1'b1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			case ((n / 160) % 3)
				0:       gap_pct = 0;
				1:       gap_pct = 75;
				default: gap_pct = 19;
			endcase
			if (shadow_len == CAPACITY && $urandom_range(7) == 0)
				grow = 1'b0;
			if (shadow_len == 0 && $urandom_range(3) == 0)
				grow = 1'b1;
			if ($urandom_range(149) == 0)
				grow = !grow;

			r.payload = {$urandom, $urandom};
			r.tag     = 8'($urandom_range(255));
			r.key     = ($urandom_range(3) == 0) ? key_pool[$urandom_range(7)] : $urandom;
			sel       = $urandom_range(999);
			if (sel < 4)
				r.kind = KIND_CLEAR;
			else if (sel < 34)
				r.kind = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
			else if (sel < 134)
				r.kind = KIND_LOCATE;
			else if (sel < 234)
				r.kind = KIND_GET;
			else if (sel < (grow ? 834 : 434))
				r.kind = KIND_INSERT;
			else
				r.kind = KIND_DELETE;

			if (r.kind == KIND_LOCATE && shadow_len > 0 && $urandom_range(9) < 6)
				r.key = shadow_list[$urandom_range(shadow_len - 1)].key;

			if ($urandom_range(9) == 0)
				r.pos = 8'($urandom_range(255));
			else if (r.kind == KIND_INSERT)
				r.pos = 8'($urandom_range(shadow_len + 1, 1));
			else if ((r.kind == KIND_DELETE || r.kind == KIND_GET) && shadow_len > 0)
				r.pos = 8'($urandom_range(shadow_len, 1));
			else
				r.pos = 8'($urandom_range(255));

			issue(r, 1'b0, '0);
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (CAPACITY + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
